/* rtl/core/ecsr_pkg.sv */
// Shared types and constants for the edge coverage sparse recorder.
package ecsr_pkg;

   localparam int ADDR_W     = 32;
   localparam int EDGE_W     = 12;
   localparam int SLOT_OUT_W = 10;
   localparam int COUNT_W    = 8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_COUNT,
      ST_DONE
   } state_type;

   // Declared MSB first so that edge_index lands in the low bits.
   typedef struct packed {
      logic                  table_full;
      logic                  new_edge;
      logic [COUNT_W-1:0]    hit_count;
      logic [SLOT_OUT_W-1:0] slot;
      logic [EDGE_W-1:0]     edge_index;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

endpackage

/* rtl/core/edge_coverage_sparse_recorder.sv */
// Edge coverage sparse recorder: edge map, slot table and sequencer.
//
// Each req transfer carries a branch return address. Its low MAP_BITS bits are
// XORed with the previous location to form the edge index, which is looked up
// in the edge map (RAM with one read and one write port). A first hit takes the
// next free slot from 1 upward; a known edge does a read-modify-write of its
// 8-bit hit count in the slot count RAM. One shared incrementer serves both the
// slot allocator and the hit counter. A new edge or a full table goes from
// ST_MAP to ST_DONE; a known edge also passes through ST_COUNT, since its map
// read is followed by its count read, each a registered RAM access. The finished
// result sits in an output register, so the next item may be taken while it
// waits for rsp_tready. After reset the edge map is swept to zero, one entry a
// cycle, with req_tready low until all 2**MAP_BITS entries are clear.
module edge_coverage_sparse_recorder
   import ecsr_pkg::*;
#(
   parameter int MAP_BITS   = 12,
   parameter int SLOT_COUNT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [ADDR_W-1:0] req_tdata,  // [31:0] return_address
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [11:0] edge_index, [21:12] slot, [29:22] hit_count, [30] new_edge,
   // [31] table_full
   output logic [RSP_W-1:0]  rsp_tdata
);

   localparam int MAP_SIZE = 1 << MAP_BITS;
   localparam int SLOT_W   = $clog2(SLOT_COUNT);
   localparam int INC_W    = (SLOT_W > COUNT_W) ? SLOT_W : COUNT_W;
   localparam logic [SLOT_W-1:0]   LAST_FREE = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [MAP_BITS-1:0] CLR_LAST  = MAP_BITS'(MAP_SIZE - 1);

   logic [SLOT_W-1:0]  edge_map [MAP_SIZE];
   logic [COUNT_W-1:0] slot_cnt [SLOT_COUNT];

   state_type state_ff, state_in;
   logic [MAP_BITS-1:0] clr_ff, clr_in;
   logic [MAP_BITS-1:0] prev_ff, prev_in;
   logic [MAP_BITS-1:0] edge_ff, edge_in;
   logic [SLOT_W-1:0]   last_ff, last_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   map_q_ff;
   logic [COUNT_W-1:0]  cnt_q_ff;

   logic                req_xfer;
   logic                rsp_free;
   logic [MAP_BITS-1:0] loc;
   logic [MAP_BITS-1:0] map_raddr;
   logic                map_we;
   logic [MAP_BITS-1:0] map_waddr;
   logic [SLOT_W-1:0]   map_wdata;
   logic [SLOT_W-1:0]   cnt_raddr;
   logic                cnt_we;
   logic [SLOT_W-1:0]   cnt_waddr;
   logic [COUNT_W-1:0]  cnt_wdata;
   logic [INC_W-1:0]    inc_a;
   logic [INC_W-1:0]    inc_sum;
   logic                table_full;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign loc        = req_tdata[MAP_BITS-1:0];
   assign map_raddr  = loc ^ prev_ff;
   assign cnt_raddr  = map_q_ff;
   assign table_full = (last_ff == LAST_FREE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // Shared incrementer: next slot number in ST_MAP, next hit count in ST_COUNT.
   assign inc_a   = (state_ff == ST_COUNT) ? INC_W'(cnt_q_ff) : INC_W'(last_ff);
   assign inc_sum = inc_a + INC_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) state_in = ST_MAP;
         end
         ST_MAP: begin
            state_in = (map_q_ff == '0) ? ST_DONE : ST_COUNT;
         end
         ST_COUNT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      clr_in       = clr_ff;
      prev_in      = prev_ff;
      edge_in      = edge_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      map_we       = 1'b0;
      map_waddr    = edge_ff;
      map_wdata    = inc_sum[SLOT_W-1:0];
      cnt_we       = 1'b0;
      cnt_waddr    = slot_ff;
      cnt_wdata    = inc_sum[COUNT_W-1:0];

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            clr_in    = clr_ff + MAP_BITS'(1);
         end
         ST_IDLE: begin
            if (req_xfer) begin
               edge_in = map_raddr;
               prev_in = loc >> 1;
            end
         end
         ST_MAP: begin
            res_in.edge_index = EDGE_W'(edge_ff);
            if (map_q_ff == '0) begin
               res_in.new_edge = 1'b1;
               if (table_full) begin
                  // no slot left: report and store nothing
                  res_in.table_full = 1'b1;
                  res_in.slot       = '0;
                  res_in.hit_count  = '0;
               end else begin
                  last_in          = inc_sum[SLOT_W-1:0];
                  map_we           = 1'b1;
                  cnt_we           = 1'b1;
                  cnt_waddr        = inc_sum[SLOT_W-1:0];
                  cnt_wdata        = COUNT_W'(1);
                  res_in.table_full = 1'b0;
                  res_in.slot       = SLOT_OUT_W'(inc_sum[SLOT_W-1:0]);
                  res_in.hit_count  = COUNT_W'(1);
               end
            end else begin
               slot_in           = map_q_ff;
               res_in.new_edge   = 1'b0;
               res_in.table_full = 1'b0;
               res_in.slot       = SLOT_OUT_W'(map_q_ff);
            end
         end
         ST_COUNT: begin
            cnt_we           = 1'b1;
            res_in.hit_count = inc_sum[COUNT_W-1:0];
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         prev_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff <= edge_in;
      slot_ff <= slot_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (map_we) edge_map[map_waddr] <= map_wdata;
      map_q_ff <= edge_map[map_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) slot_cnt[cnt_waddr] <= cnt_wdata;
      cnt_q_ff <= slot_cnt[cnt_raddr];
   end

   // Slot allocation only ever moves forward.
   a_last_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (last_ff >= $past(last_ff)))
      else $error("slot allocator moved backward");

   // A new edge with room left takes exactly the next slot.
   a_slot_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAP && map_q_ff == '0 && !table_full)
         |=> (last_ff == SLOT_W'($past(last_ff) + SLOT_W'(1))))
      else $error("new edge did not take the next slot");

   // A full-table result is always a new edge with no slot and no count.
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.table_full)
         |-> (rsp_ff.new_edge && rsp_ff.slot == '0 && rsp_ff.hit_count == '0))
      else $error("table full result carries a slot or count");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the edge coverage sparse recorder.
module tb_top;
   import ecsr_pkg::*;

   localparam int MAP_SIZE    = 4096;
   localparam int SLOT_LAST   = 1023;
   localparam int CYCLE_LIMIT = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [ADDR_W-1:0] req_tdata = '0;   // [31:0] return_address
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // [11:0] edge_index, [21:12] slot, [29:22] hit_count, [30] new_edge,
   // [31] table_full
   logic [RSP_W-1:0]  rsp_tdata;

   edge_coverage_sparse_recorder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Coverage state mirror
   logic [SLOT_OUT_W-1:0] slot_of_edge [MAP_SIZE];
   logic [EDGE_W-1:0]     edge_of_slot [SLOT_LAST+1];
   logic [COUNT_W-1:0]    hits_of_slot [SLOT_LAST+1];
   logic [SLOT_OUT_W-1:0] top_slot;
   logic [EDGE_W-1:0]     prev_loc;

   rsp_type pending_hits [$];

   int n_sent, n_checked, n_errors, n_new, n_full, n_wraps;
   int burst_left, cycles;

   function automatic rsp_type record_hit(logic [ADDR_W-1:0] addr);
      logic [EDGE_W-1:0]     loc;
      logic [SLOT_OUT_W-1:0] s;
      rsp_type               r;
      loc = addr[EDGE_W-1:0];
      r = '0;
      r.edge_index = loc ^ prev_loc;
      s = slot_of_edge[r.edge_index];
      if (s == 0) begin
         r.new_edge = 1'b1;
         if (top_slot < SLOT_LAST) begin
            top_slot = top_slot + 1'b1;
            s = top_slot;
            slot_of_edge[r.edge_index] = s;
            edge_of_slot[s] = r.edge_index;
         end else begin
            r.table_full = 1'b1;
         end
      end
      if (s != 0) begin
         hits_of_slot[s] = hits_of_slot[s] + 1'b1;
         r.slot = s;
         r.hit_count = hits_of_slot[s];
      end
      prev_loc = loc >> 1;
      return r;
   endfunction

   // Address whose low bits land on edge e given the current previous location.
   function automatic logic [ADDR_W-1:0] address_for_edge(logic [EDGE_W-1:0] e);
      return ($urandom() & 32'hffff_f000) | {20'b0, e ^ prev_loc};
   endfunction

   task automatic send_address(logic [ADDR_W-1:0] addr);
      rsp_type want;
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      want = record_hit(addr);
      pending_hits.push_back(want);
      n_sent++;
      if (want.new_edge) n_new++;
      if (want.table_full) n_full++;
      if (want.slot != 0 && want.hit_count == 0) n_wraps++;
   endtask

   // Sender holds off until every outstanding result has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic test_edge_cases();
      logic [ADDR_W-1:0] addrs [16];
      addrs = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0fff,
                32'hffff_f000, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001,
                32'h8000_0000, 32'h0000_0800, 32'h7fff_f7ff, 32'h1234_5678,
                32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 32'hdead_beef};
      foreach (addrs[i]) send_address(addrs[i]);
   endtask

   // Same site over and over: one edge past 256 hits, so its count wraps.
   task automatic test_count_wrap();
      logic [ADDR_W-1:0] addr;
      addr = $urandom();
      repeat (300) send_address(addr);
   endtask

   // Loops through a small set of sites mixed with arbitrary addresses.
   task automatic test_random_trace();
      logic [ADDR_W-1:0] sites [16];
      foreach (sites[i]) sites[i] = $urandom();
      for (int i = 0; i < 800; i++) begin
         if (i == 400) wait_for_results();
         if ($urandom_range(0, 1) == 0)
            send_address(sites[$urandom_range(0, 15)]);
         else
            send_address($urandom());
      end
   endtask

   // New edges only, until every slot is taken.
   task automatic test_fill_table();
      logic [EDGE_W-1:0] e;
      while (top_slot < SLOT_LAST) begin
         do e = EDGE_W'($urandom()); while (slot_of_edge[e] != 0);
         send_address(address_for_edge(e));
      end
   endtask

   // Table full: unslotted edges, hit again, mixed with known and random edges.
   task automatic test_table_full();
      logic [EDGE_W-1:0] e;
      logic [EDGE_W-1:0] lost_edges [$];
      for (int i = 0; i < 40; i++) begin
         do e = EDGE_W'($urandom()); while (slot_of_edge[e] != 0);
         lost_edges.push_back(e);
         send_address(address_for_edge(e));
      end
      for (int i = 0; i < 150; i++) begin
         case ($urandom_range(0, 2))
            0: e = lost_edges[$urandom_range(0, lost_edges.size() - 1)];
            1: e = edge_of_slot[$urandom_range(1, SLOT_LAST)];
            default: e = EDGE_W'($urandom());
         endcase
         send_address(address_for_edge(e));
      end
   endtask

   // Receiver back-pressure: a random mode, redrawn at regular intervals.
   int       ready_mode, stall_left;
   logic [7:0] ready_mask;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 256 == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_mask = 8'($urandom());
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: begin
            ready_mask = {ready_mask[6:0], ready_mask[7]};
            rsp_tready <= ready_mask[0];
         end
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
            end
         end
      endcase
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results missing", cycles,
                  pending_hits.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata);
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %0h", $time, rsp_tdata);
            n_errors++;
         end else begin
            want = pending_hits.pop_front();
            compare_field("edge_index", want.edge_index, got.edge_index);
            compare_field("slot", want.slot, got.slot);
            compare_field("hit_count", want.hit_count, got.hit_count);
            compare_field("new_edge", want.new_edge, got.new_edge);
            compare_field("table_full", want.table_full, got.table_full);
            n_checked++;
         end
      end
   end

   initial begin
      for (int i = 0; i < MAP_SIZE; i++) slot_of_edge[i] = '0;
      for (int i = 0; i <= SLOT_LAST; i++) begin
         edge_of_slot[i] = '0;
         hits_of_slot[i] = '0;
      end
      top_slot = '0;
      prev_loc = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_cases();
      test_count_wrap();
      wait_for_results();
      test_random_trace();
      test_fill_table();
      test_table_full();

      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d addresses traced, %0d results checked, %0d mismatches", n_sent,
               n_checked, n_errors);
      $display("%0d new edges, %0d with table full, %0d hit count wraps, %0d slots used",
               n_new, n_full, n_wraps, top_slot);
      if (n_errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
